// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the XIO interrupt register block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/xirb_pkg.sv =====
// Package of the XIO interrupt register block: command codes, status codes,
// page file geometry and the payload structs. Depends on nothing.
`default_nettype none

package xirb_pkg;

  // Page register file geometry
  localparam int PAGE_GROUPS     = 16;
  localparam int PAGES_PER_GROUP = 16;
  localparam int GRP_W           = 4;   // group field width in the command word
  localparam int ENT_W           = 4;   // entry field width in the command word
  localparam int PAGE_ADDR_W     = 1 + GRP_W + ENT_W;  // bank bit selects file
  localparam int PAGE_DEPTH      = 2 ** PAGE_ADDR_W;
  localparam logic [GRP_W:0] GROUP_LIMIT = (GRP_W + 1)'(PAGE_GROUPS);
  localparam logic [ENT_W:0] ENTRY_LIMIT = (ENT_W + 1)'(PAGES_PER_GROUP);

  // Command groups (bits 15..8 of the command word)
  localparam logic [7:0] GRP_CTRL  = 8'h20;
  localparam logic [7:0] GRP_READ  = 8'hA0;
  localparam logic [7:0] GRP_IPAGE = 8'h51;
  localparam logic [7:0] GRP_OPAGE = 8'h52;

  // Control group functions (bits 3..0)
  localparam logic [3:0] FN_SET_MASK  = 4'h0;
  localparam logic [3:0] FN_CLEAR_ALL = 4'h1;
  localparam logic [3:0] FN_ENABLE    = 4'h2;
  localparam logic [3:0] FN_DISABLE   = 4'h3;
  localparam logic [3:0] FN_RESET_BIT = 4'h4;
  localparam logic [3:0] FN_OR_PEND   = 4'h5;
  localparam logic [3:0] FN_DISCRETES = 4'h8;
  localparam logic [3:0] FN_WR_STATUS = 4'hE;

  // Read group functions
  localparam logic [3:0] FN_RD_MASK   = 4'h0;
  localparam logic [3:0] FN_RD_PEND   = 4'h4;
  localparam logic [3:0] FN_RD_STATUS = 4'hE;
  localparam logic [3:0] FN_RD_FAULT  = 4'hF;

  // Reset-pending bit numbering starts at the MSB
  localparam logic [15:0] PEND_MSB    = 16'h8000;
  localparam logic [15:0] FAULT_BIT_N = 16'd1;

  // Command status codes
  localparam logic [1:0] ST_EXECUTED = 2'd0;
  localparam logic [1:0] ST_NOOP     = 2'd1;
  localparam logic [1:0] ST_UNIMPL   = 2'd2;

  typedef struct packed {
    logic [15:0] req_type;
    logic [15:0] data_in;
    logic [15:0] external_faults;
    logic [15:0] external_interrupts;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        read_valid;
    logic        interrupts_enabled;
    logic [1:0]  command_status;
  } rsp_t;

  typedef struct packed {
    logic                   en;
    logic [PAGE_ADDR_W-1:0] addr;
    logic [15:0]            data;
  } page_wr_t;

endpackage

`default_nettype wire

// ===== rtl/xirb_if.sv =====
// Valid/ready channel interfaces for XIO commands and their results.
// Depends on nothing.
`default_nettype none

interface xirb_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] req_type;
  logic [15:0] data_in;
  logic [15:0] external_faults;
  logic [15:0] external_interrupts;

  modport source (output valid, req_type, data_in, external_faults,
                  external_interrupts, input ready);
  modport sink   (input valid, req_type, data_in, external_faults,
                  external_interrupts, output ready);
endinterface

interface xirb_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        read_valid;
  logic        interrupts_enabled;
  logic [1:0]  command_status;

  modport source (output valid, read_data, read_valid, interrupts_enabled,
                  command_status, input ready);
  modport sink   (input valid, read_data, read_valid, interrupts_enabled,
                  command_status, output ready);
endinterface

`default_nettype wire

// ===== rtl/xirb_page_file.sv =====
// Instruction and operand page register memory, one synchronous write port.
// Depends on xirb_pkg.
`default_nettype none

module xirb_page_file
  import xirb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire page_wr_t wr_i
);

  // Bank bit in the MSB: 0 instruction pages, 1 operand pages
  logic [15:0] mem_q [PAGE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xirb_ctrl.sv =====
// Command decode and interrupt/fault/status register update, one command per
// cycle while accept_i is high. Depends on xirb_pkg.
`default_nettype none

module xirb_ctrl
  import xirb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire req_t     req_i,
  output rsp_t          rsp_o,
  output page_wr_t      page_wr_o
);

  logic [15:0] mask_q, mask_d;
  logic [15:0] pend_q, pend_d;
  logic [15:0] fault_q, fault_d;
  logic [15:0] status_q, status_d;
  logic        en_q, en_d;

  logic [7:0]       grp_sel;
  logic [3:0]       fn;
  logic [GRP_W-1:0] pg_grp;
  logic [ENT_W-1:0] pg_ent;
  logic             pg_in_range;
  logic [15:0]      pend_ext;
  logic [15:0]      fault_ext;

  assign grp_sel     = req_i.req_type[15:8];
  assign fn          = req_i.req_type[3:0];
  assign pg_grp      = req_i.req_type[7:4];
  assign pg_ent      = req_i.req_type[3:0];
  assign pg_in_range = ({1'b0, pg_grp} < GROUP_LIMIT) && ({1'b0, pg_ent} < ENTRY_LIMIT);
  assign pend_ext    = pend_q | req_i.external_interrupts;
  assign fault_ext   = fault_q | req_i.external_faults;

  // Decode and next-state
  always_comb begin
    mask_d    = mask_q;
    pend_d    = pend_ext;
    fault_d   = fault_ext;
    status_d  = status_q;
    en_d      = en_q;
    rsp_o     = '0;
    page_wr_o = '0;
    page_wr_o.addr = {1'b0, pg_grp, pg_ent};
    page_wr_o.data = req_i.data_in;
    rsp_o.command_status = ST_EXECUTED;

    unique case (grp_sel)
      GRP_CTRL: begin
        unique case (fn)
          FN_SET_MASK:  mask_d = req_i.data_in;
          FN_CLEAR_ALL: begin
            pend_d  = '0;
            fault_d = '0;
          end
          FN_ENABLE:    en_d = 1'b1;
          FN_DISABLE:   en_d = 1'b0;
          FN_RESET_BIT: begin
            // bit number above 15 leaves pending alone
            if (req_i.data_in[15:4] == '0) begin
              pend_d = pend_ext & ~(PEND_MSB >> req_i.data_in[3:0]);
            end
            // bit one also drops all faults
            if (req_i.data_in == FAULT_BIT_N) begin
              fault_d = '0;
            end
          end
          FN_OR_PEND:   pend_d = pend_ext | req_i.data_in;
          FN_WR_STATUS: status_d = req_i.data_in;
          FN_DISCRETES: rsp_o.command_status = ST_UNIMPL;
          default:      rsp_o.command_status = ST_NOOP;
        endcase
      end
      GRP_READ: begin
        unique case (fn)
          FN_RD_MASK: begin
            rsp_o.read_data  = mask_q;
            rsp_o.read_valid = 1'b1;
          end
          FN_RD_PEND: begin
            rsp_o.read_data  = pend_ext;
            rsp_o.read_valid = 1'b1;
          end
          FN_RD_STATUS: begin
            rsp_o.read_data  = status_q;
            rsp_o.read_valid = 1'b1;
          end
          FN_RD_FAULT: begin
            // read includes this transfer's external faults, then clears
            rsp_o.read_data  = fault_ext;
            rsp_o.read_valid = 1'b1;
            fault_d          = '0;
          end
          default: rsp_o.command_status = ST_NOOP;
        endcase
      end
      GRP_IPAGE, GRP_OPAGE: begin
        page_wr_o.addr[PAGE_ADDR_W-1] = (grp_sel == GRP_OPAGE);
        if (pg_in_range) begin
          page_wr_o.en = accept_i;
        end else begin
          rsp_o.command_status = ST_NOOP;
        end
      end
      default: rsp_o.command_status = ST_UNIMPL;
    endcase

    rsp_o.interrupts_enabled = en_d;
  end

  // Register update on each accepted command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      pend_q   <= '0;
      fault_q  <= '0;
      status_q <= '0;
      en_q     <= 1'b0;
    end else if (accept_i) begin
      mask_q   <= mask_d;
      pend_q   <= pend_d;
      fault_q  <= fault_d;
      status_q <= status_d;
      en_q     <= en_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xirb_out_buf.sv =====
// Two-entry result buffer (output register plus skid register) that parts
// the command side from the result side. Depends on xirb_pkg.
`default_nettype none

module xirb_out_buf
  import xirb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire rsp_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  input  wire logic pop_ready_i,
  output rsp_t      data_o
);

  logic out_valid_q;
  logic skid_valid_q;
  rsp_t out_q;
  rsp_t skid_q;
  logic pop;

  assign pop     = out_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // Control: output slot fills first, skid only when output is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= data_i;
      end else begin
        out_q <= data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xio_interrupt_register_block.sv =====
// XIO interrupt register block, top level.
// Depends on xirb_pkg, xirb_if, xirb_ctrl, xirb_page_file, xirb_out_buf, assert_macros.svh.
//
// Usage: one XIO command per transfer on req_i (command word, operand and the
// external fault/interrupt bits of that step). Each command gives exactly one
// result on rsp_o: read data and its valid flag, the interrupt enable after
// the command, and a status (executed, no-op, unimplemented).
// Latency: a result is presented on rsp_o in the cycle after its command is
// taken when no earlier result waits; otherwise it follows that result.
// Throughput: one command per cycle while req_i.ready is high; the mask,
// pending, fault and status registers are read, updated and written back on
// each accepted command; a page register write is one page memory write.
// Stalls: a two-entry result buffer holds results while rsp_o.ready is low;
// req_i.ready stays high until both entries are full, so one more command is
// taken while a finished result waits.
// Reset (rst_ni low, asynchronous): mask, pending, fault, status and enable
// clear and the result buffer empties. Page memory contents are undefined
// until written; no clearing pass is run.
`default_nettype none
`include "assert_macros.svh"

module xio_interrupt_register_block
  import xirb_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  xirb_req_if.sink    req_i,
  xirb_rsp_if.source  rsp_o
);

  logic     accept;
  logic     buf_ready;
  req_t     req;
  rsp_t     rsp_new;
  rsp_t     rsp_out;
  page_wr_t page_wr;

  assign req.req_type            = req_i.req_type;
  assign req.data_in             = req_i.data_in;
  assign req.external_faults     = req_i.external_faults;
  assign req.external_interrupts = req_i.external_interrupts;

  assign req_i.ready = buf_ready;
  assign accept      = req_i.valid && buf_ready;

  // Command decode and state registers
  xirb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (req),
    .rsp_o     (rsp_new),
    .page_wr_o (page_wr)
  );

  // Page register memory
  xirb_page_file u_pages (
    .clk_i (clk_i),
    .wr_i  (page_wr)
  );

  // Result buffer
  xirb_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (rsp_new),
    .ready_o     (buf_ready),
    .valid_o     (rsp_o.valid),
    .pop_ready_i (rsp_o.ready),
    .data_o      (rsp_out)
  );

  assign rsp_o.read_data          = rsp_out.read_data;
  assign rsp_o.read_valid         = rsp_out.read_valid;
  assign rsp_o.interrupts_enabled = rsp_out.interrupts_enabled;
  assign rsp_o.command_status     = rsp_out.command_status;

  // Checks
  `ASSERT_IMP(a_full_has_output, clk_i, rst_ni, !req_i.ready, rsp_o.valid)
  `ASSERT_IMP(a_read_is_executed, clk_i, rst_ni, rsp_o.valid && rsp_o.read_valid, rsp_o.command_status == ST_EXECUTED)
  `ASSERT_IMP(a_no_read_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.read_valid, rsp_o.read_data == 16'h0000)
  `ASSERT_IMP(a_page_wr_on_accept, clk_i, rst_ni, page_wr.en, req_i.valid && req_i.ready)
  `ASSERT_NXT(a_accept_gives_result, clk_i, rst_ni, req_i.valid && req_i.ready, rsp_o.valid)

endmodule

`default_nettype wire
